FILE: rtl/multigrid_restrict_3d_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multigrid restriction core
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MULTIGRID_RESTRICT_3D_CORE_MACROS_SVH
`define MULTIGRID_RESTRICT_3D_CORE_MACROS_SVH

// same-cycle implication
`define MGR3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MGR3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mgr3_pkg.sv
// ----------------------------------------------------------------------------
// mgr3_pkg
// Shared constants and types of the 3-D multigrid restriction core.
// ----------------------------------------------------------------------------
package mgr3_pkg;

    localparam int CFG_SIZE_W = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index is paddr[APB_ADDR_W-1:2]
    localparam logic [APB_ADDR_W-3:0] REG_COARSE_SIZE = 1'b0;
    localparam logic [CFG_SIZE_W-1:0] COARSE_SIZE_RST = 7'd65;
    localparam int MIN_COARSE = 2;

    // 0.5 and 0.0833 in units of 2^-16
    localparam int CENTER_SHIFT = 15;
    localparam int FACE_WEIGHT  = 5459;
    localparam int WEIGHT_W     = 14;
    localparam int FRAC_BITS    = 16;
    localparam int NB_COUNT     = 6;

    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_CNT_W = 4;
    localparam int CREDIT_W    = 4;

    typedef enum logic [1:0] {
        K_NONE,
        K_COPY_X,
        K_COPY_CTR,
        K_INT
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  odd_plane;
        logic  done;
    } t_s1_tag;

    typedef struct packed {
        logic valid;
        logic face;
        logic done;
    } t_evt_ctl;

endpackage

FILE: rtl/mgr3_if.sv
// ----------------------------------------------------------------------------
// mgr3 stream interfaces
// Valid/ready channels for fine samples in and coarse values out.
// ----------------------------------------------------------------------------
interface mgr3_in_if #(
    parameter int SAMPLE_WIDTH = 32
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] fine_sample;

    modport source (output valid, output fine_sample, input ready);
    modport sink   (input valid, input fine_sample, output ready);
endinterface

interface mgr3_out_if #(
    parameter int SAMPLE_WIDTH = 32
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] coarse_value;
    logic                           grid_done;

    modport source (output valid, output coarse_value, output grid_done, input ready);
    modport sink   (input valid, input coarse_value, input grid_done, output ready);
endinterface

FILE: rtl/mgr3_bank.sv
// ----------------------------------------------------------------------------
// mgr3_bank
// One fine-plane buffer: one write port, two registered read ports.
// Port A shares its address with the write and returns the old contents.
// ----------------------------------------------------------------------------
module mgr3_bank #(
    parameter int DEPTH = 16641,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_addr];
            r_rd_b <= r_mem[i_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

FILE: rtl/mgr3_weigh.sv
// ----------------------------------------------------------------------------
// mgr3_weigh
// Weighted stencil: sum of six face neighbours, constant multiply, floor
// shift and clamp. Face points ride along and bypass the arithmetic.
// ----------------------------------------------------------------------------
module mgr3_weigh
    import mgr3_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_evt_ctl                              i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_face_val,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_center,
    input  logic [NB_COUNT-1:0][SAMPLE_WIDTH-1:0] i_nb,
    output t_evt_ctl                              o_ctl,
    output logic [SAMPLE_WIDTH-1:0]               o_value,
    output logic [1:0]                            o_occupancy
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUM_W = SW + 3;
    localparam int ACC_W = SUM_W + WEIGHT_W;
    localparam logic signed [WEIGHT_W-1:0] FACE_W_S = WEIGHT_W'(FACE_WEIGHT);

    t_evt_ctl                 r_w1_ctl;
    logic signed [SUM_W-1:0]  r_w1_sum;
    logic signed [SW-1:0]     r_w1_center;
    logic signed [SW-1:0]     r_w1_face_val;
    t_evt_ctl                 r_w2_ctl;
    logic signed [ACC_W-1:0]  r_w2_acc;
    logic signed [SW-1:0]     r_w2_face_val;

    logic signed [SUM_W-1:0]  n_sum;
    logic signed [ACC_W-1:0]  w_center_ext;
    logic signed [ACC_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [SW:0]       w_q;
    logic [SW-1:0]            w_sat;

    // three pair sums, then one three-input add
    assign n_sum = (SUM_W'($signed(i_nb[0])) + SUM_W'($signed(i_nb[1])))
                 + (SUM_W'($signed(i_nb[2])) + SUM_W'($signed(i_nb[3])))
                 + (SUM_W'($signed(i_nb[4])) + SUM_W'($signed(i_nb[5])));

    assign w_center_ext = ACC_W'(r_w1_center);
    assign w_prod       = r_w1_sum * FACE_W_S;
    assign n_acc        = (w_center_ext <<< CENTER_SHIFT) + w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1_ctl <= '0;
            r_w2_ctl <= '0;
        end else begin
            r_w1_ctl <= i_ctl;
            r_w2_ctl <= r_w1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1_sum      <= n_sum;
        r_w1_center   <= i_center;
        r_w1_face_val <= i_face_val;
        r_w2_acc      <= n_acc;
        r_w2_face_val <= r_w1_face_val;
    end

    // arithmetic shift gives floor; clamp when the top two bits disagree
    assign w_q = r_w2_acc[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (w_q[SW] != w_q[SW-1]) begin
            w_sat = w_q[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            w_sat = w_q[SW-1:0];
        end
    end

    assign o_value     = r_w2_ctl.face ? r_w2_face_val : w_sat;
    assign o_ctl       = r_w2_ctl;
    assign o_occupancy = 2'(r_w1_ctl.valid) + 2'(r_w2_ctl.valid);

endmodule

FILE: rtl/mgr3_ofifo.sv
// ----------------------------------------------------------------------------
// mgr3_ofifo
// Small result queue between the fixed-latency datapath and the output
// channel; absorbs receiver stalls.
// ----------------------------------------------------------------------------
module mgr3_ofifo
    import mgr3_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [SAMPLE_WIDTH-1:0] i_value,
    input  logic                    i_done,
    output logic [OFIFO_CNT_W-1:0]  o_count,
    mgr3_out_if.source              o_out
);

    localparam int PTR_W = $clog2(OFIFO_DEPTH);

    logic [SAMPLE_WIDTH:0]    r_mem [OFIFO_DEPTH];
    logic [PTR_W-1:0]         r_wr_ptr;
    logic [PTR_W-1:0]         r_rd_ptr;
    logic [OFIFO_CNT_W-1:0]   r_count;
    logic [OFIFO_CNT_W-1:0]   n_count;
    logic                     w_pop;

    assign w_pop = o_out.valid & o_out.ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= {i_done, i_value};
        end
    end

    assign o_out.valid        = (r_count != '0);
    assign o_out.coarse_value = r_mem[r_rd_ptr][SAMPLE_WIDTH-1:0];
    assign o_out.grid_done    = r_mem[r_rd_ptr][SAMPLE_WIDTH];
    assign o_count            = r_count;

endmodule

FILE: rtl/multigrid_restrict_3d_core.sv
// ----------------------------------------------------------------------------
// multigrid_restrict_3d_core
// 3-D half-weighting restriction of a streamed fine cube onto its coarse grid.
// Fine samples (edge 2n-1, raster order, plane slowest) arrive on i_in; coarse
// values (edge n, raster order) leave on o_out with grid_done on the last one.
// n is set over APB (register 0, coarse_size); a write also restarts the grid,
// so write it only while no transfer is in progress.
// One fine sample is taken per cycle while i_in.ready is high. The two plane
// buffers are read-first memories: each transfer reads and writes at its own
// entry and reads one more neighbour entry.
// A face value passes stage 1, the event stage, the weighting registers and
// the output queue on its way to o_out; an interior value takes the same path
// once the next sample (its east neighbour) has been taken.
// After reset the size is 65 and the position is the start of a grid; the
// buffers hold nothing meaningful until written, and no clearing pass runs.
// When the receiver stalls, results gather in an 8-entry queue; i_in.ready
// drops once the queue plus the values still in the pipeline would fill it.
// ----------------------------------------------------------------------------
`include "multigrid_restrict_3d_core_macros.svh"

module multigrid_restrict_3d_core
    import mgr3_pkg::*;
#(
    parameter int MAX_COARSE   = 65,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mgr3_in_if.sink               i_in,
    mgr3_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW          = SAMPLE_WIDTH;
    localparam int FINE_MAX    = 2 * MAX_COARSE - 1;
    localparam int PLANE_DEPTH = FINE_MAX * FINE_MAX;
    localparam int AW          = $clog2(PLANE_DEPTH);
    localparam int PW          = $clog2(FINE_MAX + 1);
    localparam int NW          = $clog2(MAX_COARSE + 1);
    localparam int CW          = (NW > CFG_SIZE_W) ? NW : CFG_SIZE_W;

    // configuration and position
    logic [CFG_SIZE_W-1:0] r_coarse_size;
    logic [PW-1:0]         r_plane, r_row, r_col;
    logic [PW-1:0]         n_plane, n_row, n_col;
    logic [AW-1:0]         r_row_base, n_row_base;
    logic [CW-1:0]         w_size_ext, w_coarse_n;
    logic [PW:0]           w_twice_n;
    logic [PW-1:0]         w_last_pos;
    logic                  w_cfg_wr, w_cfg_hit, w_accept;

    // address and classification of the incoming sample
    logic [AW-1:0]         w_addr, w_addr_b;
    logic                  w_even, w_last_plane, w_face;
    t_s1_tag               n_s1_tag;

    // plane buffer read data
    logic [SW-1:0]         w_b0_a, w_b0_b, w_b1_a, w_b1_b;

    // stage 1: memory data valid
    logic                  r_s1_valid;
    t_s1_tag               r_s1_tag;
    logic signed [SW-1:0]  r_s1_x;
    logic signed [SW-1:0]  w_prev_a, w_prev_b, w_old_a;
    logic signed [SW-1:0]  r_west;

    // interior point waiting for its east and south neighbours
    logic                  r_pend, n_pend;
    logic signed [SW-1:0]  r_pend_center, r_pend_north, r_pend_x, r_pend_pp, r_pend_west;

    // event stage into the arithmetic
    t_evt_ctl              r_e_ctl, n_e_ctl;
    logic signed [SW-1:0]  r_e_face_val, n_e_face_val;
    logic signed [SW-1:0]  r_e_center;
    logic [NB_COUNT-1:0][SW-1:0] r_e_nb, n_e_nb;

    t_evt_ctl              w_res_ctl;
    logic [SW-1:0]         w_res_value;
    logic [1:0]            w_weigh_occ;
    logic [OFIFO_CNT_W-1:0] w_fifo_count;
    logic [CREDIT_W-1:0]   w_credit;

    // ------------------------------------------------------------------ config
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_hit = w_cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_COARSE_SIZE);
    assign pready    = 1'b1;
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_COARSE_SIZE)
                     ? APB_DATA_W'(r_coarse_size) : '0;

    assign w_size_ext = CW'(r_coarse_size);

    always_comb begin
        if (w_size_ext < CW'(MIN_COARSE)) begin
            w_coarse_n = CW'(MIN_COARSE);
        end else if (w_size_ext > CW'(MAX_COARSE)) begin
            w_coarse_n = CW'(MAX_COARSE);
        end else begin
            w_coarse_n = w_size_ext;
        end
    end

    // last fine index 2n-2
    assign w_twice_n  = {PW'(w_coarse_n), 1'b0};
    assign w_last_pos = w_twice_n[PW-1:0] - PW'(2);

    // ---------------------------------------------------------------- position
    assign w_accept = i_in.valid & i_in.ready;

    always_comb begin
        n_plane    = r_plane;
        n_row      = r_row;
        n_col      = r_col;
        n_row_base = r_row_base;
        if (w_cfg_hit) begin
            n_plane    = '0;
            n_row      = '0;
            n_col      = '0;
            n_row_base = '0;
        end else if (w_accept) begin
            if (r_col == w_last_pos) begin
                n_col = '0;
                if (r_row == w_last_pos) begin
                    n_row      = '0;
                    n_row_base = '0;
                    n_plane    = (r_plane == w_last_pos) ? '0 : r_plane + 1'b1;
                end else begin
                    n_row      = r_row + 1'b1;
                    n_row_base = r_row_base + AW'(FINE_MAX);
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse_size <= COARSE_SIZE_RST;
            r_plane       <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_row_base    <= '0;
        end else begin
            if (w_cfg_hit) begin
                r_coarse_size <= pwdata[CFG_SIZE_W-1:0];
            end
            r_plane    <= n_plane;
            r_row      <= n_row;
            r_col      <= n_col;
            r_row_base <= n_row_base;
        end
    end

    // ---------------------------------------------------- addressing, classify
    assign w_addr = r_row_base + AW'(r_col);

    // even column: north entry; odd column: south entry of the column before
    always_comb begin
        if (!r_col[0]) begin
            w_addr_b = (r_row == '0) ? w_addr : w_addr - AW'(FINE_MAX);
        end else begin
            w_addr_b = (r_row == w_last_pos) ? w_addr : w_addr + AW'(FINE_MAX - 1);
        end
    end

    assign w_even       = !r_row[0] && !r_col[0];
    assign w_last_plane = (r_plane == w_last_pos);
    assign w_face       = (r_plane == PW'(1)) || (r_row == '0) || (r_row == w_last_pos)
                       || (r_col == '0) || (r_col == w_last_pos);

    always_comb begin
        n_s1_tag.odd_plane = r_plane[0];
        n_s1_tag.done      = w_last_plane && (r_row == w_last_pos) && (r_col == w_last_pos);
        if (w_even && w_last_plane) begin
            n_s1_tag.kind = K_COPY_X;
        end else if (w_even && r_plane[0]) begin
            n_s1_tag.kind = w_face ? K_COPY_CTR : K_INT;
        end else begin
            n_s1_tag.kind = K_NONE;
        end
    end

    // ----------------------------------------------------------- plane buffers
    // older bank takes even planes, newer bank odd planes
    mgr3_bank #(
        .DEPTH (PLANE_DEPTH),
        .WIDTH (SW)
    ) u_bank_older (
        .i_clk       (i_clk),
        .i_wr_en     (w_accept && !r_plane[0]),
        .i_addr      (w_addr),
        .i_wr_data   (i_in.fine_sample),
        .i_rd_en     (w_accept),
        .i_addr_b    (w_addr_b),
        .o_rd_data_a (w_b0_a),
        .o_rd_data_b (w_b0_b)
    );

    mgr3_bank #(
        .DEPTH (PLANE_DEPTH),
        .WIDTH (SW)
    ) u_bank_newer (
        .i_clk       (i_clk),
        .i_wr_en     (w_accept && r_plane[0]),
        .i_addr      (w_addr),
        .i_wr_data   (i_in.fine_sample),
        .i_rd_en     (w_accept),
        .i_addr_b    (w_addr_b),
        .o_rd_data_a (w_b1_a),
        .o_rd_data_b (w_b1_b)
    );

    // --------------------------------------------------------------- stage 1
    assign w_prev_a = r_s1_tag.odd_plane ? w_b0_a : w_b1_a;
    assign w_prev_b = r_s1_tag.odd_plane ? w_b0_b : w_b1_b;
    assign w_old_a  = r_s1_tag.odd_plane ? w_b1_a : w_b0_a;

    always_comb begin
        n_pend       = r_pend;
        n_e_ctl      = '0;
        n_e_face_val = w_prev_a;
        n_e_nb       = {r_pend_x, r_pend_pp, r_pend_north, w_prev_b, w_prev_a, r_pend_west};
        if (r_s1_valid) begin
            if (r_pend) begin
                // this transfer is the east neighbour: interior point complete
                n_pend        = 1'b0;
                n_e_ctl.valid = 1'b1;
            end else begin
                case (r_s1_tag.kind)
                    K_COPY_X: begin
                        n_e_ctl      = '{valid: 1'b1, face: 1'b1, done: r_s1_tag.done};
                        n_e_face_val = r_s1_x;
                    end
                    K_COPY_CTR: begin
                        n_e_ctl = '{valid: 1'b1, face: 1'b1, done: r_s1_tag.done};
                    end
                    K_INT: begin
                        n_pend = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pend     <= 1'b0;
            r_e_ctl    <= '0;
        end else begin
            r_s1_valid <= w_accept;
            r_pend     <= n_pend;
            r_e_ctl    <= n_e_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tag <= n_s1_tag;
            r_s1_x   <= i_in.fine_sample;
        end
        if (r_s1_valid) begin
            r_west       <= w_prev_a;
            r_e_face_val <= n_e_face_val;
            r_e_center   <= r_pend_center;
            r_e_nb       <= n_e_nb;
            if (!r_pend && r_s1_tag.kind == K_INT) begin
                r_pend_center <= w_prev_a;
                r_pend_north  <= w_prev_b;
                r_pend_x      <= r_s1_x;
                r_pend_pp     <= w_old_a;
                r_pend_west   <= r_west;
            end
        end
    end

    // ------------------------------------------------------------- arithmetic
    mgr3_weigh #(
        .SAMPLE_WIDTH (SW)
    ) u_weigh (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_e_ctl),
        .i_face_val  (r_e_face_val),
        .i_center    (r_e_center),
        .i_nb        (r_e_nb),
        .o_ctl       (w_res_ctl),
        .o_value     (w_res_value),
        .o_occupancy (w_weigh_occ)
    );

    // ----------------------------------------------------------- output queue
    mgr3_ofifo #(
        .SAMPLE_WIDTH (SW)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_ctl.valid),
        .i_value (w_res_value),
        .i_done  (w_res_ctl.done),
        .o_count (w_fifo_count),
        .o_out   (o_out)
    );

    // every sample in flight may still yield one value; keep room for all
    assign w_credit = CREDIT_W'(r_s1_valid) + CREDIT_W'(r_e_ctl.valid) + CREDIT_W'(r_pend)
                    + CREDIT_W'(w_weigh_occ) + CREDIT_W'(w_fifo_count);
    assign i_in.ready = (w_credit < CREDIT_W'(OFIFO_DEPTH));

    // ------------------------------------------------------------- assertions
    `MGR3_ASSERT_IMP(a_queue_room, i_clk, i_rst_n, w_res_ctl.valid, w_fifo_count < OFIFO_CNT_W'(OFIFO_DEPTH), "result pushed into a full output queue")
    `MGR3_ASSERT_IMP(a_pend_tail_quiet, i_clk, i_rst_n, r_pend && r_s1_valid, r_s1_tag.kind == K_NONE, "sample after an interior point expected to yield nothing")
    `MGR3_ASSERT_NXT(a_pend_resolves, i_clk, i_rst_n, r_pend && r_s1_valid, !r_pend, "interior point not completed by the following sample")

endmodule

FILE: verif/tb_multigrid_restrict_3d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multigrid_restrict_3d_core
// Self-checking bench for the 3-D restriction core. Fine grids of several
// edges stream in through the valid/ready input while both sides idle at
// random. A local predictor keeps its own plane buffers and grid position,
// and each coarse transfer is compared in order against it.
// ----------------------------------------------------------------------------
module tb_multigrid_restrict_3d_core;
    import mgr3_pkg::*;

    localparam int     MAX_COARSE    = 65;
    localparam int     SAMPLE_WIDTH  = 32;
    localparam int     FINE_EDGE     = 2 * MAX_COARSE - 1;
    localparam int     PLANE_WORDS   = FINE_EDGE * FINE_EDGE;
    localparam longint CTR_WT        = 32768;
    localparam longint FACE_WT       = 5459;
    localparam longint SAMPLE_MAX    = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN    = -SAMPLE_MAX - 1;
    localparam int     RANDOM_ITEMS  = 60;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     CYCLE_LIMIT   = 2_000_000;

    localparam logic [APB_ADDR_W-3:0] REG_SPARE  = 1'b1;
    localparam logic [APB_ADDR_W-1:0] ADDR_SIZE  = {REG_COARSE_SIZE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           done;
    } t_coarse;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mgr3_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) fine_ch ();
    mgr3_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) coarse_ch ();

    multigrid_restrict_3d_core #(
        .MAX_COARSE  (MAX_COARSE),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (fine_ch),
        .o_out  (coarse_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #4 i_clk = ~i_clk;

    // samples waiting to be driven, and coarse values still owed by the core
    logic signed [SAMPLE_WIDTH-1:0] fine_q[$];
    t_coarse                        coarse_q[$];
    int                             fine_pending;

    // predictor state
    logic signed [SAMPLE_WIDTH-1:0] plane_buf [2][PLANE_WORDS];
    logic [CFG_SIZE_W-1:0]          size_reg;
    int                             plane_at;
    int                             row_at;
    int                             col_at;

    int idle_pct;
    int gap_left;
    int stall_left;
    int fail_count;
    int cycle_count;

    function automatic void restrict_fine_sample(input logic signed [SAMPLE_WIDTH-1:0] x);
        int      n, f, p, r, c, at, wr, rd, cp, cr, cc;
        longint  face_sum, acc;
        t_coarse res;
        bit      hit;
        n = int'(size_reg);
        if (n < MIN_COARSE) n = MIN_COARSE;
        if (n > MAX_COARSE) n = MAX_COARSE;
        f = 2 * n - 1;
        p = plane_at;
        r = row_at;
        c = col_at;
        if (p >= f || r >= f || c >= f) begin
            p = 0;
            r = 0;
            c = 0;
        end
        at = r * FINE_EDGE + c;
        // odd planes write the second bank, and the first holds plane p-1
        wr = p % 2;
        rd = 1 - wr;
        hit = 1'b0;
        res.value = x;
        if (r % 2 == 0 && c % 2 == 0) begin
            if (p == f - 1) begin
                hit = 1'b1;
            end else if (wr == 1) begin
                cp = (p - 1) / 2;
                cr = r / 2;
                cc = c / 2;
                res.value = plane_buf[rd][at];
                if (cp != 0 && cr != 0 && cc != 0 &&
                    cp != n - 1 && cr != n - 1 && cc != n - 1) begin
                    face_sum = longint'(x) + longint'(plane_buf[wr][at])
                             + longint'(plane_buf[rd][at + FINE_EDGE])
                             + longint'(plane_buf[rd][at - FINE_EDGE])
                             + longint'(plane_buf[rd][at + 1])
                             + longint'(plane_buf[rd][at - 1]);
                    // shift floors toward minus infinity
                    acc = (CTR_WT * longint'(plane_buf[rd][at]) + FACE_WT * face_sum) >>> 16;
                    if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
                    if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
                    res.value = acc[SAMPLE_WIDTH-1:0];
                end
                hit = 1'b1;
            end
        end
        if (hit) begin
            res.done = (p == f - 1 && r == f - 1 && c == f - 1);
            coarse_q.push_back(res);
        end
        plane_buf[wr][at] = x;
        c++;
        if (c >= f) begin
            c = 0;
            r++;
            if (r >= f) begin
                r = 0;
                p++;
                if (p >= f) p = 0;
            end
        end
        plane_at = p;
        row_at = r;
        col_at = c;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] corner_sample(input int k);
        case (k % 9)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h5555_5555;
            6: return 32'hAAAA_AAAA;
            7: return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: begin
                v = int'($urandom_range(0, 511)) - 256;
                return v;
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
        fine_q.push_back(s);
        fine_pending++;
    endtask

    task automatic queue_random(input int count);
        repeat (count) queue_sample(pick_sample());
    endtask

    // every sample taken and every coarse value back, then a settling pause
    task automatic wait_idle();
        while (fine_pending != 0 || coarse_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_size(input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] got;
        apb_write(ADDR_SIZE, data);
        size_reg = data[CFG_SIZE_W-1:0];
        plane_at = 0;
        row_at   = 0;
        col_at   = 0;
        @(posedge i_clk);
        psel  <= 1'b1;
        paddr <= ADDR_SIZE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DATA_W'(data[CFG_SIZE_W-1:0])) begin
            $error("coarse_size readback: expected %0d, actual %0d",
                   data[CFG_SIZE_W-1:0], got);
            fail_count++;
        end
    endtask

    // input driver: presents queued samples, predicts on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fine_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (fine_ch.valid && fine_ch.ready) begin
                restrict_fine_sample(fine_ch.fine_sample);
                fine_pending--;
            end
            if (!fine_ch.valid || fine_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    fine_ch.valid <= 1'b0;
                end else if (fine_q.size() != 0 && idle_pct != 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(1, 11) - 1;
                    fine_ch.valid <= 1'b0;
                end else if (fine_q.size() != 0) begin
                    fine_ch.valid       <= 1'b1;
                    fine_ch.fine_sample <= fine_q.pop_front();
                end else begin
                    fine_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor with random receiver stalls
    always @(posedge i_clk) begin : coarse_monitor
        t_coarse want;
        if (!i_rst_n) begin
            coarse_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (coarse_ch.valid && coarse_ch.ready) begin
                if (coarse_q.size() == 0) begin
                    $error("coarse transfer with nothing expected: coarse_value %0d",
                           coarse_ch.coarse_value);
                    fail_count++;
                end else begin
                    want = coarse_q.pop_front();
                    if (coarse_ch.coarse_value !== want.value) begin
                        $error("coarse_value: expected %0d, actual %0d",
                               want.value, coarse_ch.coarse_value);
                        fail_count++;
                    end
                    if (coarse_ch.grid_done !== want.done) begin
                        $error("grid_done: expected %0d, actual %0d",
                               want.done, coarse_ch.grid_done);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                coarse_ch.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 11) - 1;
                coarse_ch.ready <= 1'b0;
            end else begin
                coarse_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [APB_DATA_W-1:0] wdata;
        int n_eff, f_eff, span, cut, random_items;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        fine_ch.valid       = 1'b0;
        fine_ch.fine_sample = '0;
        coarse_ch.ready     = 1'b0;
        size_reg            = COARSE_SIZE_RST;
        plane_at            = 0;
        row_at              = 0;
        col_at              = 0;
        fine_pending        = 0;
        fail_count          = 0;
        cycle_count         = 0;
        idle_pct            = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a few samples at the reset edge, then a size write breaks into the grid
        for (int i = 0; i < 5; i++) queue_sample(corner_sample(i));
        wait_idle();
        // size 1 is taken as 2; upper data bits must be dropped
        program_size(32'hFFFF_FF81);
        idle_pct = 20;
        for (int i = 0; i < 27; i++) queue_sample(corner_sample(i));
        wait_idle();

        // largest edge: one full fine row and the wrap into the next
        program_size(32'd127);
        idle_pct = 10;
        queue_random(FINE_EDGE + 2);
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: n_eff = 2;
                4, 5, 6, 7: n_eff = 3;
                8:          n_eff = 4;
                default:    n_eff = $urandom_range(0, 1);
            endcase
            wdata = $urandom();
            wdata[CFG_SIZE_W-1:0] = CFG_SIZE_W'(n_eff);
            program_size(wdata);
            if (n_eff < MIN_COARSE) n_eff = MIN_COARSE;
            f_eff = 2 * n_eff - 1;
            span = f_eff ** 3;
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            // every stop lands on a row end, so no interior value is left waiting
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 5))
                    0: begin
                        cut = $urandom_range(1, f_eff * f_eff - 1) * f_eff;
                        queue_random(cut);
                        random_items += cut;
                    end
                    1: begin
                        // write to the unused index mid-grid: position carries on
                        cut = $urandom_range(1, f_eff * f_eff - 1) * f_eff;
                        queue_random(cut);
                        wait_idle();
                        apb_write(ADDR_SPARE, $urandom());
                        queue_random(span - cut);
                        random_items += span;
                    end
                    default: begin
                        queue_random(span);
                        random_items += span;
                    end
                endcase
            end
            wait_idle();
        end

        // closing grid with both sides streaming freely
        idle_pct = 0;
        program_size(32'd3);
        queue_random(125);
        wait_idle();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
